[hw/rtl/swmv_pkg.sv]
`default_nettype none
package swmv_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_W     = 7;
  localparam int MEAN_W    = 24;
  localparam int VAR_W     = 39;
  localparam int STD_W     = 24;
  localparam int FRAC_BITS = 8;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(8);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_UPD  = 10'b0000000010,
    ST_MUL  = 10'b0000000100,
    ST_VST  = 10'b0000001000,
    ST_VDIV = 10'b0000010000,
    ST_MST  = 10'b0000100000,
    ST_MDIV = 10'b0001000000,
    ST_SST  = 10'b0010000000,
    ST_SQRT = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } swmv_state_t;

endpackage
`default_nettype wire

[hw/rtl/swmv_if.sv]
`default_nettype none
interface swmv_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;
  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface swmv_out_if;
  import swmv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_q8;
  logic [VAR_W-1:0]         variance_q8;
  logic [STD_W-1:0]         std_q8;
  logic                     variance_defined;
  modport source (output valid, mean_q8, variance_q8, std_q8, variance_defined,
                  input ready);
  modport sink   (input valid, mean_q8, variance_q8, std_q8, variance_defined,
                  output ready);
endinterface

interface swmv_cfg_if;
  import swmv_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sliding_window_mean_variance_std_unit.sv]
// Sliding-window mean, sample variance and standard deviation.
// in_chan carries a signed sample and a restart flag; restart begins a new
// series. cfg_chan writes the window length W (0 acts as 1, values above
// MAX_WINDOW saturate); a write also ends the current series. Write it only
// while the block is idle.
// The last W samples sit in a ring memory with a registered read; running
// sum and sum of squares are updated by read-modify-write. Once W samples
// of a series are in, each sample yields one transfer on out_chan with
// mean, variance and std in Q8; earlier samples yield nothing.
// One item at a time: a result passes through the shared serial divider
// (one bit per cycle) for variance and then mean, and through the serial
// square root; W of one skips the variance division and the root.
// Reset clears the series, sets W to 8 and empties the output register.
// A stalled out_chan holds its result; the block takes the next sample
// meanwhile and waits only when a new result is ready to be stored.
`default_nettype none
module sliding_window_mean_variance_std_unit
  import swmv_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  swmv_in_if.sink    in_chan,
  swmv_out_if.source out_chan,
  swmv_cfg_if.sink   cfg_chan
);
  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + AW + 1;
  localparam int SQW  = 2 * SAMPLE_BITS - 1 + AW;
  localparam int DW   = WW + SQW;
  localparam int NW   = DW + 2 * FRAC_BITS;
  localparam int DENW = 2 * WW;
  localparam int RW   = (NW + 1) / 2;

  swmv_state_t state_r, state_nxt;

  logic [CFG_W-1:0] window_r;
  logic [WW-1:0]    w_eff;
  logic [AW-1:0]    pos_r;
  logic [WW-1:0]    fill_r;
  logic signed [SUMW-1:0] sum_r;
  logic [SQW-1:0]   sq_r;
  logic signed [SAMPLE_BITS-1:0] x_r;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic [AW-1:0] rd_addr;

  logic [DW-1:0]   pw_r, ps_r;
  logic [SUMW-1:0] sabs_r;
  logic            sneg_r;
  logic [NW-1:0]   vq_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic [STD_W-1:0] std_r;

  logic            out_valid_r;
  logic signed [MEAN_W-1:0] out_mean_r;
  logic [VAR_W-1:0] out_var_r;
  logic [STD_W-1:0] out_std_r;
  logic             out_def_r;

  logic in_fire, cfg_fire, out_fire;
  logic w_one;

  // per-sample pre-adjust
  logic [AW-1:0]    cur_pos;
  logic [WW-1:0]    cur_fill;
  logic signed [SUMW-1:0] cur_sum;
  logic [SQW-1:0]   cur_sq;

  // update stage
  logic            full;
  logic [SAMPLE_BITS-1:0] old_mag, new_mag;
  logic signed [SUMW-1:0] upd_sum;
  logic [SQW-1:0]   upd_sq;
  logic [WW-1:0]    upd_fill;
  logic [AW-1:0]    upd_pos;

  // divider / sqrt
  logic            div_start, div_done;
  logic [NW-1:0]   div_n, div_q;
  logic [DENW-1:0] div_d, div_rem;
  logic            sq_start, sq_done;
  logic [RW-1:0]   sq_root;
  logic signed [NW:0] mean_full;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;

  always_comb begin
    if (window_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(window_r) > MAX_WINDOW) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(window_r);
    end
  end
  assign w_one = (w_eff == WW'(1));

  always_comb begin
    if (in_chan.restart) begin
      cur_pos  = '0;
      cur_fill = '0;
      cur_sum  = '0;
      cur_sq   = '0;
    end else begin
      cur_pos  = pos_r;
      cur_fill = fill_r;
      cur_sum  = sum_r;
      cur_sq   = sq_r;
    end
    if (WW'(cur_pos) >= w_eff) begin
      cur_pos = '0;
    end
  end
  assign rd_addr = cur_pos;

  always_ff @(posedge clk) begin
    rd_q <= ring[rd_addr];
    if (state_r == ST_UPD) begin
      ring[pos_r] <= x_r;
    end
  end

  always_comb begin
    full    = (fill_r >= w_eff);
    old_mag = rd_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_q) : SAMPLE_BITS'(rd_q);
    new_mag = x_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_r) : SAMPLE_BITS'(x_r);
    upd_sum = sum_r + SUMW'(x_r);
    upd_sq  = sq_r + SQW'(new_mag * new_mag);
    if (full) begin
      upd_sum  = upd_sum - SUMW'(rd_q);
      upd_sq   = upd_sq - SQW'(old_mag * old_mag);
      upd_fill = fill_r;
    end else begin
      upd_fill = fill_r + 1'b1;
    end
    upd_pos = (WW'(pos_r) + 1'b1 >= w_eff) ? '0 : pos_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (upd_fill >= w_eff) ? ST_MUL : ST_IDLE;
      ST_MUL:  state_nxt = ST_VST;
      ST_VST:  state_nxt = w_one ? ST_MST : ST_VDIV;
      ST_VDIV: if (div_done) state_nxt = ST_MST;
      ST_MST:  state_nxt = ST_MDIV;
      ST_MDIV: if (div_done) state_nxt = w_one ? ST_OUT : ST_SST;
      ST_SST:  state_nxt = ST_SQRT;
      ST_SQRT: if (sq_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      window_r <= WINDOW_RESET;
      pos_r    <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      sq_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        window_r <= cfg_chan.data;
        pos_r    <= '0;
        fill_r   <= '0;
        sum_r    <= '0;
        sq_r     <= '0;
      end else if (in_fire) begin
        pos_r  <= cur_pos;
        fill_r <= cur_fill;
        sum_r  <= cur_sum;
        sq_r   <= cur_sq;
      end else if (state_r == ST_UPD) begin
        pos_r  <= upd_pos;
        fill_r <= upd_fill;
        sum_r  <= upd_sum;
        sq_r   <= upd_sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= in_chan.sample;
    end
    if (state_r == ST_MUL) begin
      sneg_r <= sum_r[SUMW-1];
      sabs_r <= sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
      pw_r   <= DW'(w_eff * sq_r);
      ps_r   <= DW'((sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r))
                    * (sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r)));
    end
    if (state_r == ST_VST) begin
      vq_r <= '0;
    end else if (state_r == ST_VDIV && div_done) begin
      vq_r <= div_q;
    end
    if (state_r == ST_MDIV && div_done) begin
      mean_r <= MEAN_W'(mean_full);
      std_r  <= '0;
    end else if (state_r == ST_SQRT && sq_done) begin
      std_r <= STD_W'(sq_root);
    end
  end

  // mean floors toward minus infinity: bump magnitude when inexact
  assign mean_full = sneg_r ? -((NW+1)'(div_q) + (NW+1)'(div_rem != '0))
                            : (NW+1)'(div_q);

  always_comb begin
    div_start = 1'b0;
    div_n     = NW'(sabs_r) << FRAC_BITS;
    div_d     = DENW'(w_eff);
    if (state_r == ST_VST && !w_one) begin
      div_start = 1'b1;
      div_n     = NW'(pw_r - ps_r) << (2 * FRAC_BITS);
      div_d     = DENW'(w_eff * (w_eff - 1'b1));
    end else if (state_r == ST_MST) begin
      div_start = 1'b1;
    end
  end
  assign sq_start = (state_r == ST_SST);

  swmv_div #(.NW(NW), .DENW(DENW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  swmv_isqrt #(.NW(NW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (vq_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_chan.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_chan.ready)) begin
      out_mean_r <= mean_r;
      out_var_r  <= VAR_W'(vq_r >> FRAC_BITS);
      out_std_r  <= std_r;
      out_def_r  <= !w_one;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.mean_q8          = out_mean_r;
  assign out_chan.variance_q8      = out_var_r;
  assign out_chan.std_q8           = out_std_r;
  assign out_chan.variance_defined = out_def_r;
endmodule
`default_nettype wire

[hw/rtl/swmv_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module swmv_div
  import swmv_pkg::*;
#(
  parameter int NW   = 60,
  parameter int DENW = 14
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NW-1:0]   dividend,
  input  wire logic [DENW-1:0] divisor,
  output logic                 done,
  output logic [NW-1:0]        quotient,
  output logic [DENW-1:0]      remainder
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DENW-1:0] den_r;
  logic [DENW:0]   rem_r, rem_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [DENW:0]   trial;

  always_comb begin
    trial = {rem_r[DENW-1:0], q_r[NW-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt   = {q_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt   = {q_r[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      rem_r <= '0;
      q_r   <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[DENW-1:0];
endmodule
`default_nettype wire

[hw/rtl/swmv_isqrt.sv]
`default_nettype none
// Integer square root, two radicand bits per cycle.
module swmv_isqrt
  import swmv_pkg::*;
#(
  parameter int NW = 60
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] radicand,
  output logic               done,
  output logic [(NW+1)/2-1:0] root
);
  localparam int RW   = (NW + 1) / 2;
  localparam int SW   = 2 * RW;
  localparam int CNTW = $clog2(RW + 1);

  logic [SW-1:0]   v_r, root_r, bit_r;
  logic [SW-1:0]   trial;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(RW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= SW'(radicand);
      root_r <= '0;
      bit_r  <= SW'(1) << (SW - 2);
    end else if (cnt_r != '0) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = root_r[RW-1:0];
endmodule
`default_nettype wire

[dv/tb_sliding_window_mean_variance_std_unit.sv]
module tb_sliding_window_mean_variance_std_unit;
  import swmv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RING_DEPTH  = 64;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  SETTLE_CYCLES = 200;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_q8;
    logic [VAR_W-1:0]         variance_q8;
    logic [STD_W-1:0]         std_q8;
    logic                     variance_defined;
  } window_stats_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               restart;
    logic               typed;
    window_stats_t      stats;
  } stim_row_t;

  logic clk;
  logic rst_n;

  swmv_in_if #(.SAMPLE_BITS(16)) in_chan();
  swmv_out_if                    out_chan();
  swmv_cfg_if                    cfg_chan();

  sliding_window_mean_variance_std_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_chan (cfg_chan.sink)
  );

  // predictor state
  logic signed [15:0] ring_mdl [RING_DEPTH];
  int unsigned        wr_pos_mdl;
  int unsigned        fill_mdl;
  longint             sum_mdl;
  longint             sq_sum_mdl;
  logic [CFG_W-1:0]   window_reg_mdl;

  window_stats_t pending_stats[$];
  int            err_count;
  longint        cycle_count;
  bit            calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void clear_series();
    wr_pos_mdl = 0;
    fill_mdl   = 0;
    sum_mdl    = 0;
    sq_sum_mdl = 0;
  endfunction

  // Updates the window and returns 1 when the sample completes a full window.
  function automatic bit window_update(input logic signed [15:0] x, input logic restart,
                                       output window_stats_t st);
    int unsigned     w;
    longint          old, xv, num, q;
    longint unsigned d, den;
    w = window_reg_mdl;
    if (w == 0) w = 1;
    if (w > RING_DEPTH) w = RING_DEPTH;
    xv = x;
    if (restart) clear_series();
    if (wr_pos_mdl >= w) wr_pos_mdl = 0;
    if (fill_mdl >= w) begin
      old = ring_mdl[wr_pos_mdl];
      sum_mdl -= old;
      sq_sum_mdl -= old * old;
    end else begin
      fill_mdl++;
    end
    ring_mdl[wr_pos_mdl] = x;
    sum_mdl += xv;
    sq_sum_mdl += xv * xv;
    wr_pos_mdl = (wr_pos_mdl + 1 >= w) ? 0 : wr_pos_mdl + 1;
    if (fill_mdl < w) return 0;
    num = sum_mdl * 256;
    q = num / longint'(w);
    if ((num % longint'(w)) != 0 && num < 0) q--;
    st.mean_q8 = q[MEAN_W-1:0];
    st.variance_q8 = '0;
    st.std_q8 = '0;
    st.variance_defined = 1'b0;
    if (w > 1) begin
      d   = longint'(w) * sq_sum_mdl - sum_mdl * sum_mdl;
      den = longint'(w) * longint'(w - 1);
      st.variance_q8 = VAR_W'((d * 256) / den);
      st.std_q8 = STD_W'(int_sqrt((d * 65536) / den));
      st.variance_defined = 1'b1;
    end
    return 1;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic signed [15:0] x, input logic restart,
                             input bit typed, input window_stats_t typed_stats);
    window_stats_t st;
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.sample  <= x;
    in_chan.restart <= restart;
    do @(posedge clk); while (!in_chan.ready);
    if (window_update(x, restart, st)) pending_stats.push_back(typed ? typed_stats : st);
    @(negedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= w;
    do @(posedge clk); while (!cfg_chan.ready);
    window_reg_mdl = w;
    clear_series();
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    if (r < 4) return 16'($urandom);
    return 16'($signed($urandom_range(0, 400)) - 200);
  endfunction

  task automatic random_phase(input int n_items);
    window_stats_t none;
    none = '0;
    for (int i = 0; i < n_items; i++) begin
      send_sample(pick_sample(), ($urandom_range(0, 99) < 3) ? 1'b1 : 1'b0, 1'b0, none);
      // now and then hold off mid-phase until the output side catches up
      if (i == n_items / 2 && $urandom_range(0, 3) == 0) begin
        in_chan.valid <= 1'b0;
        while (pending_stats.size() != 0) @(negedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sliding_window_mean_variance_std_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    window_stats_t exp_st, got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.mean_q8          = out_chan.mean_q8;
      got.variance_q8      = out_chan.variance_q8;
      got.std_q8           = out_chan.std_q8;
      got.variance_defined = out_chan.variance_defined;
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected transfer mean %0d var %0d std %0d def %0b", $realtime,
                 got.mean_q8, got.variance_q8, got.std_q8, got.variance_defined);
        err_count++;
      end else begin
        exp_st = pending_stats.pop_front();
        if (got.mean_q8 !== exp_st.mean_q8) begin
          $display("%0t: mean_q8 exp %0d got %0d", $realtime, exp_st.mean_q8, got.mean_q8);
          err_count++;
        end
        if (got.variance_q8 !== exp_st.variance_q8) begin
          $display("%0t: variance_q8 exp %0d got %0d", $realtime,
                   exp_st.variance_q8, got.variance_q8);
          err_count++;
        end
        if (got.std_q8 !== exp_st.std_q8) begin
          $display("%0t: std_q8 exp %0d got %0d", $realtime, exp_st.std_q8, got.std_q8);
          err_count++;
        end
        if (got.variance_defined !== exp_st.variance_defined) begin
          $display("%0t: variance_defined exp %0b got %0b", $realtime,
                   exp_st.variance_defined, got.variance_defined);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= calm || ($urandom_range(0, 99) >= 36);
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [CFG_W-1:0] windows[$];

    err_count = 0;
    cycle_count = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.sample = '0;
    in_chan.restart = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data = '0;
    out_chan.ready = 1'b0;
    foreach (ring_mdl[i]) ring_mdl[i] = '0;
    window_reg_mdl = WINDOW_RESET;
    clear_series();

    // full-scale positive window, full-scale negative window, alternating, then a zero
    for (int i = 0; i < 25; i++) begin
      row.typed = 1'b0;
      row.stats = '0;
      row.restart = (i == 0 || i == 8 || i == 16);
      if (i < 8) row.sample = 16'sh7fff;
      else if (i < 16) row.sample = 16'sh8000;
      else if (i < 24) row.sample = (i % 2 == 0) ? 16'sh7fff : 16'sh8000;
      else row.sample = 16'sh0000;
      if (i == 7) begin
        row.typed = 1'b1;
        row.stats = '{mean_q8: 24'sd8388352, variance_q8: '0, std_q8: '0,
                      variance_defined: 1'b1};
      end
      if (i == 15) begin
        row.typed = 1'b1;
        row.stats = '{mean_q8: -24'sd8388608, variance_q8: '0, std_q8: '0,
                      variance_defined: 1'b1};
      end
      rows.push_back(row);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_sample(rows[i].sample, rows[i].restart, rows[i].typed,
                                  rows[i].stats);
    drain();

    // window one, zero (acts as one), max, saturating, small and random sizes
    windows = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd3, 7'd100, 7'd8,
                7'($urandom_range(1, 16)), 7'($urandom_range(1, 64))};
    foreach (windows[p]) begin
      write_window(windows[p]);
      calm = (p == 4);
      random_phase(133);
      drain();
      calm = 1'b0;
    end

    if (err_count == 0) begin
      $display("tb_sliding_window_mean_variance_std_unit: done, clean");
    end else begin
      $display("tb_sliding_window_mean_variance_std_unit: done, errors");
    end
    $finish;
  end

endmodule
